[hw/rtl/mlfq_thread_scheduler_top_macros.svh]
// Assertion macros shared by the scheduler RTL.
`ifndef MLFQ_THREAD_SCHEDULER_TOP_MACROS_SVH
`define MLFQ_THREAD_SCHEDULER_TOP_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define MLFQ_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication checked outside reset.
`define MLFQ_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

[hw/rtl/mlfq_pkg.sv]
package mlfq_pkg;
	localparam int MAX_THREADS = 64;
	localparam int NUM_LEVELS  = 10;
	localparam int NUM_CLASSES = 4;
	localparam int NUM_QUEUES  = NUM_LEVELS * NUM_CLASSES;
	localparam int TID_W = $clog2(MAX_THREADS);
	localparam int LVL_W = 4;
	localparam int CLS_W = 2;
	localparam int Q_W   = $clog2(NUM_QUEUES);
	localparam int CNT_W = 7;
	localparam int SLICE_W = 10;
	localparam logic FUNC_ENQ = 1'b0;
	localparam logic FUNC_SEL = 1'b1;

	typedef struct packed {
		logic             func;
		logic [TID_W-1:0] thread_id;
		logic [CLS_W-1:0] process_class;
		logic             is_new;
	} in_item_t;

	typedef struct packed {
		logic               found;
		logic [TID_W-1:0]   picked_thread;
		logic [LVL_W-1:0]   picked_level;
		logic [SLICE_W-1:0] slice_ticks;
		logic [CLS_W-1:0]   picked_class;
		logic [CNT_W-1:0]   queued_count;
	} out_item_t;
endpackage

[hw/rtl/mlfq_thread_scheduler_top.sv]
// Multilevel feedback queue scheduler, one item at a time.
// After its input transfer an enqueue passes through RD, WR and OUT, and a select
// through RD, LINK, WR and OUT (the extra LINK state reads the head's link).
// A new item is taken in the cycle after the result transfers, so the block never
// takes a new item before it is through with the last one.
// Reset (asynchronous, active low) clears written marks, used marks, waiting marks,
// queue nonempty bits and the count; level, link, head and tail memories need no clearing.
module mlfq_thread_scheduler_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  mlfq_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output mlfq_pkg::out_item_t out_data
);
	import mlfq_pkg::*;
	`include "mlfq_thread_scheduler_top_macros.svh"

	// Sequencer states. Each item walks RD -> (LINK) -> WR -> OUT.
	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_RD   = 5'b00010,
		ST_LINK = 5'b00100,
		ST_WR   = 5'b01000,
		ST_OUT  = 5'b10000
	} state_t;

	state_t state_q;
	in_item_t item_q;
	out_item_t res_q;
	out_item_t res_nxt;

	// Per-thread flags with reset values live in flip-flops: whether the level
	// entry was ever written, the used mark and whether the thread is waiting.
	// A level entry that was never written reads as level 0.
	logic [MAX_THREADS-1:0] lvl_ok_q, used_q, inq_q;
	logic [NUM_QUEUES-1:0] nonempty_q;
	logic [CNT_W-1:0] count_q;

	// Synchronous memories: thread levels, queue heads, queue tails and FIFO links.
	logic [LVL_W-1:0] lvl_mem [MAX_THREADS];
	logic [TID_W-1:0] head_mem [NUM_QUEUES];
	logic [TID_W-1:0] tail_mem [NUM_QUEUES];
	logic [TID_W-1:0] link_mem [MAX_THREADS];
	logic [LVL_W-1:0] lvl_rd;
	logic [TID_W-1:0] head_rd, tail_rd, link_rd;

	// Queue chosen for this item. A select fixes it at transfer, an enqueue
	// once its level has been read from memory.
	logic [Q_W-1:0] q_q;
	logic [Q_W-1:0] q_addr;
	logic [LVL_W-1:0] newlvl_q;
	logic hit_q;

	// Enqueue level update and queue index, valid while the item sits in RD.
	logic [LVL_W-1:0] enq_lvl;
	logic [Q_W-1:0] enq_q;
	logic enq_ok;
	always_comb begin
		enq_lvl = lvl_ok_q[item_q.thread_id] ? lvl_rd : '0;
		if (item_q.is_new) begin
			enq_lvl = '0;
		end else if (used_q[item_q.thread_id] && enq_lvl < LVL_W'(NUM_LEVELS-1)) begin
			enq_lvl = enq_lvl + 1'b1;
		end
		if (enq_lvl >= LVL_W'(NUM_LEVELS)) begin
			enq_lvl = LVL_W'(NUM_LEVELS-1);
		end
		enq_ok = !inq_q[item_q.thread_id];
		enq_q = Q_W'(enq_lvl) * Q_W'(NUM_CLASSES) + Q_W'(item_q.process_class);
	end

	// Lowest nonempty queue, a priority search over the 40 nonempty bits.
	logic [Q_W-1:0] sel_q;
	logic sel_any;
	always_comb begin
		sel_q = '0;
		sel_any = 1'b0;
		for (int i = NUM_QUEUES-1; i >= 0; i--) begin
			if (nonempty_q[i]) begin
				sel_q = Q_W'(i);
				sel_any = 1'b1;
			end
		end
	end

	logic [LVL_W-1:0] q_lvl;
	logic [CLS_W-1:0] q_cls;
	assign q_lvl = LVL_W'(q_q / NUM_CLASSES);
	assign q_cls = CLS_W'(q_q % NUM_CLASSES);

	// While an enqueue is in RD its queue comes straight from the level just read.
	assign q_addr = (state_q == ST_RD && item_q.func == FUNC_ENQ) ? enq_q : q_q;

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	assign out_data  = res_q;

	// Result of the item, registered at the end of WR.
	always_comb begin
		res_nxt = '0;
		if (item_q.func == FUNC_SEL && hit_q) begin
			res_nxt.found = 1'b1;
			res_nxt.picked_thread = head_rd;
			res_nxt.picked_level = q_lvl;
			res_nxt.slice_ticks = SLICE_W'(1) << q_lvl;
			res_nxt.picked_class = q_cls;
			res_nxt.queued_count = count_q - 1'b1;
		end else if (item_q.func == FUNC_ENQ && hit_q) begin
			res_nxt.queued_count = count_q + 1'b1;
		end else begin
			res_nxt.queued_count = count_q;
		end
	end

	always_ff @(posedge clk) begin
		lvl_rd <= lvl_mem[in_data.thread_id];
		head_rd <= head_mem[q_addr];
		tail_rd <= tail_mem[q_addr];
		link_rd <= link_mem[head_rd];
		if (state_q == ST_WR && hit_q) begin
			if (item_q.func == FUNC_ENQ) begin
				lvl_mem[item_q.thread_id] <= newlvl_q;
				if (nonempty_q[q_q]) begin
					link_mem[tail_rd] <= item_q.thread_id;
				end else begin
					head_mem[q_q] <= item_q.thread_id;
				end
				tail_mem[q_q] <= item_q.thread_id;
			end else if (tail_rd != head_rd) begin
				head_mem[q_q] <= link_rd;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			item_q <= in_data;
			q_q <= sel_q;
			hit_q <= sel_any;
		end
		if (state_q == ST_RD && item_q.func == FUNC_ENQ) begin
			q_q <= enq_q;
			hit_q <= enq_ok;
			newlvl_q <= enq_lvl;
		end
		if (state_q == ST_WR) begin
			res_q <= res_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			lvl_ok_q <= '0;
			used_q <= '0;
			inq_q <= '0;
			nonempty_q <= '0;
			count_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: if (in_valid) state_q <= ST_RD;
				ST_RD:   state_q <= (item_q.func == FUNC_SEL) ? ST_LINK : ST_WR;
				ST_LINK: state_q <= ST_WR;
				ST_WR: begin
					state_q <= ST_OUT;
					if (hit_q && item_q.func == FUNC_ENQ) begin
						lvl_ok_q[item_q.thread_id] <= 1'b1;
						used_q[item_q.thread_id] <= 1'b0;
						inq_q[item_q.thread_id] <= 1'b1;
						nonempty_q[q_q] <= 1'b1;
						count_q <= count_q + 1'b1;
					end else if (hit_q) begin
						used_q[head_rd] <= 1'b1;
						inq_q[head_rd] <= 1'b0;
						if (tail_rd == head_rd) nonempty_q[q_q] <= 1'b0;
						count_q <= count_q - 1'b1;
					end
				end
				ST_OUT: if (!out_stall) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`MLFQ_ASSERT_IMP(a_count_range, clk, arst_n, 1'b1, count_q <= CNT_W'(MAX_THREADS), "count overflow")
	`MLFQ_ASSERT_IMP(a_count_match, clk, arst_n, 1'b1, count_q == CNT_W'($countones(inq_q)), "count mismatch")
	`MLFQ_ASSERT_IMP(a_found_sel, clk, arst_n, out_valid && res_q.found, item_q.func == FUNC_SEL, "found on enqueue")
	`MLFQ_ASSERT_NXT(a_no_accept_busy, clk, arst_n, state_q == ST_RD, in_stall, "accepted while busy")
endmodule
